>>> hdl/tsc_pkg.sv
`default_nettype none

package tsc_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned PROD_W   = TIME_W + FREQ_W;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Quotient bits resolved in each divider stage.
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES = PROD_W / DIV_BITS_PER_STAGE;

  localparam logic [FREQ_W-1:0] NS_PER_SECOND = 32'd1_000_000_000;
  localparam logic [FREQ_W-1:0] FREQ_RESET    = NS_PER_SECOND;

  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_FREQ_HZ = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_ENABLED = 8'd1;

  localparam logic ACTION_NS_TO_TICKS = 1'b0;
  localparam logic ACTION_TICKS_TO_NS = 1'b1;

  localparam logic STATUS_OK            = 1'b0;
  localparam logic STATUS_NOT_AVAILABLE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [TIME_W-1:0] time_value;
  } tsc_in_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] converted_value;
    logic                     status;
    logic                     overflow;
  } tsc_out_t;

  // Per-item flags that ride alongside the arithmetic.
  typedef struct packed {
    logic negative;
    logic disabled;
    logic div_zero;
  } tsc_side_t;

endpackage

`default_nettype wire

>>> hdl/tsc_mul.sv
`default_nettype none

module tsc_mul
  import tsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire tsc_side_t         side_i,
  input  wire logic [TIME_W-1:0] mag_i,
  input  wire logic [FREQ_W-1:0] mul_i,
  input  wire logic [FREQ_W-1:0] div_i,
  output logic                   valid_o,
  output tsc_side_t              side_o,
  output logic [FREQ_W-1:0]      div_o,
  output logic [PROD_W-1:0]      prod_o
);

  localparam int unsigned HALF_W = TIME_W / 2;
  localparam int unsigned PART_W = HALF_W + FREQ_W;

  logic                s1_valid_r;
  tsc_side_t           s1_side_r;
  logic [FREQ_W-1:0]   s1_div_r;
  logic [PART_W-1:0]   s1_prod_lo_r;
  logic [PART_W-1:0]   s1_prod_hi_r;

  logic                s2_valid_r;
  tsc_side_t           s2_side_r;
  logic [FREQ_W-1:0]   s2_div_r;
  logic [PROD_W-1:0]   s2_prod_r;
  logic [PROD_W-1:0]   s2_prod_nxt;

  // Two 32x32 partial products, summed in the next stage.
  assign s2_prod_nxt = {s1_prod_hi_r, {HALF_W{1'b0}}}
                     + {{(PROD_W - PART_W){1'b0}}, s1_prod_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= valid_i;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r    <= side_i;
      s1_div_r     <= div_i;
      s1_prod_lo_r <= PART_W'(mag_i[HALF_W-1:0]) * PART_W'(mul_i);
      s1_prod_hi_r <= PART_W'(mag_i[TIME_W-1:HALF_W]) * PART_W'(mul_i);
      s2_side_r    <= s1_side_r;
      s2_div_r     <= s1_div_r;
      s2_prod_r    <= s2_prod_nxt;
    end
  end

  assign valid_o = s2_valid_r;
  assign side_o  = s2_side_r;
  assign div_o   = s2_div_r;
  assign prod_o  = s2_prod_r;

endmodule

`default_nettype wire

>>> hdl/tsc_div_stage.sv
`default_nettype none

module tsc_div_stage
  import tsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire tsc_side_t         side_i,
  input  wire logic [FREQ_W-1:0] div_i,
  input  wire logic [FREQ_W-1:0] rem_i,
  input  wire logic [PROD_W-1:0] work_i,
  output logic                   valid_o,
  output tsc_side_t              side_o,
  output logic [FREQ_W-1:0]      div_o,
  output logic [FREQ_W-1:0]      rem_o,
  output logic [PROD_W-1:0]      work_o
);

  logic                valid_r;
  tsc_side_t           side_r;
  logic [FREQ_W-1:0]   div_r;
  logic [FREQ_W-1:0]   rem_r;
  logic [PROD_W-1:0]   work_r;
  logic [FREQ_W-1:0]   rem_nxt;
  logic [PROD_W-1:0]   work_nxt;

  // Restoring division: the dividend shifts out of the top of work while
  // quotient bits shift in at the bottom. The remainder stays below div.
  always_comb begin
    logic [FREQ_W:0] trial;
    rem_nxt  = rem_i;
    work_nxt = work_i;
    for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
      trial    = {rem_nxt, work_nxt[PROD_W-1]};
      work_nxt = {work_nxt[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_i}) begin
        trial       = trial - {1'b0, div_i};
        work_nxt[0] = 1'b1;
      end
      rem_nxt = trial[FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      div_r  <= div_i;
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign div_o   = div_r;
  assign rem_o   = rem_r;
  assign work_o  = work_r;

endmodule

`default_nettype wire

>>> hdl/tsc_out.sv
`default_nettype none

module tsc_out
  import tsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     valid_i,
  input  wire tsc_out_t data_i,
  input  wire logic     out_stall,
  output logic          out_valid,
  output tsc_out_t      out_data,
  output logic          full
);

  logic     out_valid_r;
  tsc_out_t out_data_r;
  logic     skid_valid_r;
  tsc_out_t skid_data_r;
  logic     take;

  assign take = out_valid_r && !out_stall;

  // While the skid register is full the pipeline is frozen, so valid_i is
  // only consumed when the skid register is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= valid_i;
    end else if (valid_i) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || take) begin
      if (valid_i) begin
        out_data_r <= data_i;
      end
    end else if (valid_i) begin
      skid_data_r <= data_i;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

endmodule

`default_nettype wire

>>> hdl/timestamp_scale_converter.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   tsc_in_t  (action, time_value)
// out_     output     out_valid / out_stall tsc_out_t (converted_value, status, overflow)
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item enters per cycle while in_stall is low; each accepted item passes through, in order:
// an input register, two multiply stages, 24 divider stages of four quotient bits each,
// and the output register.
// Reset is synchronous and active low; it empties the pipeline, loads the counter
// frequency with 1 GHz and disables the service.
// A stall on the output fills a one-item skid register, which stalls the input and
// freezes the pipeline until the skid register drains.
`default_nettype none

module timestamp_scale_converter
  import tsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tsc_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tsc_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FREQ_W-1:0] counter_freq_hz_r;
  logic              service_enabled_r;

  logic              en;
  logic              skid_full;

  logic              s0_valid_r;
  tsc_side_t         s0_side_r;
  logic [TIME_W-1:0] s0_mag_r;
  logic [FREQ_W-1:0] s0_mul_r;
  logic [FREQ_W-1:0] s0_div_r;
  tsc_side_t         s0_side_nxt;
  logic [TIME_W-1:0] s0_mag_nxt;
  logic [FREQ_W-1:0] s0_mul_nxt;
  logic [FREQ_W-1:0] s0_div_nxt;

  logic [DIV_STAGES:0] dv_valid;
  tsc_side_t           dv_side [DIV_STAGES+1];
  logic [FREQ_W-1:0]   dv_div  [DIV_STAGES+1];
  logic [FREQ_W-1:0]   dv_rem  [DIV_STAGES+1];
  logic [PROD_W-1:0]   dv_work [DIV_STAGES+1];

  tsc_out_t          result;
  logic [TIME_W-1:0] quot_low;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_freq_hz_r <= FREQ_RESET;
      service_enabled_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COUNTER_FREQ_HZ: counter_freq_hz_r <= cfg_data[FREQ_W-1:0];
        REG_SERVICE_ENABLED: service_enabled_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless the skid register holds an item.
  assign en       = !skid_full;
  assign in_stall = skid_full;

  always_comb begin
    s0_side_nxt.negative = in_data.time_value[TIME_W-1];
    s0_side_nxt.disabled = !service_enabled_r;
    s0_mag_nxt = s0_side_nxt.negative ? (~in_data.time_value + TIME_W'(1))
                                      : in_data.time_value;
    if (in_data.action == ACTION_TICKS_TO_NS) begin
      s0_mul_nxt = NS_PER_SECOND;
      s0_div_nxt = counter_freq_hz_r;
    end else begin
      s0_mul_nxt = counter_freq_hz_r;
      s0_div_nxt = NS_PER_SECOND;
    end
    s0_side_nxt.div_zero = (s0_div_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= s0_side_nxt;
      s0_mag_r  <= s0_mag_nxt;
      s0_mul_r  <= s0_mul_nxt;
      s0_div_r  <= s0_div_nxt;
    end
  end

  tsc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (s0_valid_r),
    .side_i  (s0_side_r),
    .mag_i   (s0_mag_r),
    .mul_i   (s0_mul_r),
    .div_i   (s0_div_r),
    .valid_o (dv_valid[0]),
    .side_o  (dv_side[0]),
    .div_o   (dv_div[0]),
    .prod_o  (dv_work[0])
  );

  assign dv_rem[0] = '0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tsc_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (dv_valid[g]),
      .side_i  (dv_side[g]),
      .div_i   (dv_div[g]),
      .rem_i   (dv_rem[g]),
      .work_i  (dv_work[g]),
      .valid_o (dv_valid[g+1]),
      .side_o  (dv_side[g+1]),
      .div_o   (dv_div[g+1]),
      .rem_o   (dv_rem[g+1]),
      .work_o  (dv_work[g+1])
    );
  end

  // Quotient bits above the low 64 are dropped and flag the overflow.
  assign quot_low = dv_work[DIV_STAGES][TIME_W-1:0];

  always_comb begin
    if (dv_side[DIV_STAGES].disabled) begin
      result.converted_value = '0;
      result.status          = STATUS_NOT_AVAILABLE;
      result.overflow        = 1'b0;
    end else if (dv_side[DIV_STAGES].div_zero) begin
      result.converted_value = '0;
      result.status          = STATUS_OK;
      result.overflow        = 1'b1;
    end else begin
      result.converted_value = dv_side[DIV_STAGES].negative
                             ? (~quot_low + TIME_W'(1)) : quot_low;
      result.status          = STATUS_OK;
      result.overflow        = |dv_work[DIV_STAGES][PROD_W-1:TIME_W];
    end
  end

  tsc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (dv_valid[DIV_STAGES]),
    .data_i    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (skid_full)
  );

endmodule

`default_nettype wire

>>> test/timestamp_scale_converter_tb.sv
`timescale 1ns / 100ps

module timestamp_scale_converter_tb;
  import tsc_pkg::*;

  localparam int PIPE_LATENCY    = 28;
  localparam int DRAIN_CYCLES    = 2 * PIPE_LATENCY;
  localparam int CYCLE_LIMIT     = 500_000;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 110;

  localparam logic [TIME_W-1:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0] TIME_MIN = 64'h8000_0000_0000_0000;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 32'hFFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  tsc_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tsc_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the configuration registers, starting at their reset values.
  logic [FREQ_W-1:0] freq_hz = FREQ_RESET;
  logic              service_on = 1'b0;

  tsc_in_t  pending_items[$];
  tsc_out_t expected_results[$];

  int mismatches  = 0;
  int cycle_count = 0;
  int send_wait   = 0;
  int send_calm   = 0;
  int recv_wait   = 0;
  int recv_calm   = 0;

  timestamp_scale_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Scales the magnitude at full product width, then restores the sign.
  function automatic tsc_out_t predict_conversion(tsc_in_t item);
    tsc_out_t          res;
    logic [TIME_W-1:0] raw;
    logic [TIME_W-1:0] mag;
    logic [FREQ_W-1:0] mul;
    logic [FREQ_W-1:0] dvs;
    logic [PROD_W-1:0] quot;
    logic              neg;
    res = '0;
    if (!service_on) begin
      res.status = STATUS_NOT_AVAILABLE;
      return res;
    end
    raw = item.time_value;
    neg = raw[TIME_W-1];
    mag = neg ? (~raw) + TIME_W'(1) : raw;
    if (item.action == ACTION_NS_TO_TICKS) begin
      mul = freq_hz;
      dvs = NS_PER_SECOND;
    end else begin
      mul = NS_PER_SECOND;
      dvs = freq_hz;
    end
    res.status = STATUS_OK;
    if (dvs == '0) begin
      res.overflow = 1'b1;
      return res;
    end
    quot = ({{FREQ_W{1'b0}}, mag} * {{TIME_W{1'b0}}, mul}) / {{TIME_W{1'b0}}, dvs};
    res.overflow = |quot[PROD_W-1:TIME_W];
    res.converted_value = neg ? (~quot[TIME_W-1:0]) + TIME_W'(1) : quot[TIME_W-1:0];
    return res;
  endfunction

  // Mostly random waits, with occasional stretches of back-to-back items.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [TIME_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      1: v = v >> $urandom_range(0, 63);
      2: v = (~(v >> $urandom_range(0, 63))) + TIME_W'(1);
      3: v = {{40{v[23]}}, v[23:0]};
      4: v = TIME_MAX - TIME_W'(v[15:0]);
      5: v = TIME_MIN + TIME_W'(v[15:0]);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 7))
      0: return 32'd1;
      1: return FREQ_MAX;
      2: return '0;
      3: return NS_PER_SECOND;
      4: return NS_PER_SECOND + FREQ_W'($urandom_range(0, 2000)) - FREQ_W'(1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic action, logic [TIME_W-1:0] value);
    tsc_in_t item;
    item.action     = action;
    item.time_value = value;
    pending_items.push_back(item);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_COUNTER_FREQ_HZ: freq_hz = data;
      REG_SERVICE_ENABLED: service_on = data[0];
      default: ;
    endcase
  endtask

  // Checked at the falling edge so that every handshake of the cycle has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  always @(posedge clk) begin : drive_items
    logic hold;
    hold = in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_conversion(in_data));
        hold = 1'b0;
        send_wait = draw_wait(send_calm);
      end
      if (!hold) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          hold = 1'b1;
        end
      end
      in_valid <= hold;
    end
  end

  always @(posedge clk) begin : check_results
    tsc_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: %h", out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.converted_value !== want.converted_value) begin
            $error("converted_value: expected %0d, actual %0d",
                   want.converted_value, out_data.converted_value);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, out_data.overflow);
            mismatches++;
          end
        end
        recv_wait = draw_wait(recv_calm);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run_phases
    logic [CFG_DATA_W-1:0] enable_word;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still hold their reset values, so the service is off.
    add_item(ACTION_NS_TO_TICKS, '0);
    add_item(ACTION_TICKS_TO_NS, TIME_MAX);
    add_item(ACTION_NS_TO_TICKS, TIME_MIN);
    repeat (20) add_item(1'($urandom_range(0, 1)), rand_time());
    wait_drained();

    // Unity scale at the reset frequency; the most negative input comes back as itself.
    write_register(REG_SERVICE_ENABLED, $urandom | 32'd1);
    add_item(ACTION_NS_TO_TICKS, '0);
    add_item(ACTION_NS_TO_TICKS, 64'd1);
    add_item(ACTION_TICKS_TO_NS, '1);
    add_item(ACTION_NS_TO_TICKS, TIME_MAX);
    add_item(ACTION_TICKS_TO_NS, TIME_MAX);
    add_item(ACTION_NS_TO_TICKS, TIME_MIN);
    add_item(ACTION_TICKS_TO_NS, TIME_MIN);
    wait_drained();

    write_register(REG_COUNTER_FREQ_HZ, 32'd1);
    add_item(ACTION_NS_TO_TICKS, TIME_MAX);
    add_item(ACTION_TICKS_TO_NS, TIME_MAX);
    add_item(ACTION_TICKS_TO_NS, '1);
    wait_drained();

    write_register(REG_COUNTER_FREQ_HZ, FREQ_MAX);
    add_item(ACTION_NS_TO_TICKS, TIME_MAX);
    add_item(ACTION_TICKS_TO_NS, TIME_MIN);
    wait_drained();

    // Doubling: quotients just under 2^64 wrap without overflow, 2^64 itself overflows.
    write_register(REG_COUNTER_FREQ_HZ, 32'd2_000_000_000);
    add_item(ACTION_NS_TO_TICKS, TIME_MAX);
    add_item(ACTION_NS_TO_TICKS, TIME_MIN + TIME_W'(1));
    add_item(ACTION_NS_TO_TICKS, TIME_MIN);
    wait_drained();

    // A zero frequency divides by zero in one direction and multiplies by zero in the other.
    write_register(REG_COUNTER_FREQ_HZ, '0);
    add_item(ACTION_TICKS_TO_NS, 64'd12345);
    add_item(ACTION_NS_TO_TICKS, TIME_MIN);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      enable_word = $urandom;
      enable_word[0] = (p != 4) && ($urandom_range(0, 7) != 0);
      write_register(REG_COUNTER_FREQ_HZ, pick_freq());
      write_register(REG_SERVICE_ENABLED, enable_word);
      // Writes to indexes outside the map must leave both registers alone.
      write_register(CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1)), $urandom);
      repeat (ITEMS_PER_PHASE) add_item(1'($urandom_range(0, 1)), rand_time());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tsc_pkg.sv
hdl/tsc_mul.sv
hdl/tsc_div_stage.sv
hdl/tsc_out.sv
hdl/timestamp_scale_converter.sv
test/timestamp_scale_converter_tb.sv
